// ===== design/plci_pkg.sv =====
// ----------------------------------------------------------------------------
// plci_pkg: shared types and constants for the leaky clamped integrator core
// Operand and result formats of the shared multiply/round unit, shift codes,
// and the sign helper used by the accumulators.
// ----------------------------------------------------------------------------
package plci_pkg;

	// Fixed fraction widths of the step time and the leak factor
	localparam int STEP_FRAC = 24;
	localparam int LEAK_FRAC = 16;

	// Multiplier widths: A carries error or integrator magnitudes, B gains, step time or leak
	localparam int A_W   = 33;
	localparam int B_W   = 32;
	localparam int P_W   = A_W + B_W;
	localparam int M_W   = P_W + 1;
	localparam int ACC_W = M_W + 3;

	// Rounding shift selectors
	localparam logic [1:0] SH_STEP = 2'd0;
	localparam logic [1:0] SH_LEAK = 2'd1;
	localparam logic [1:0] SH_GAIN = 2'd2;

	typedef struct packed {
		logic           vld;
		logic [A_W-1:0] a;
		logic [B_W-1:0] b;
		logic           neg;
		logic [1:0]     sh;
	} mul_req_t;

	typedef struct packed {
		logic [M_W-1:0] mag;
		logic           neg;
	} mul_res_t;

	// Turn a rounded magnitude and its sign into a wide two's complement value
	function automatic logic signed [ACC_W-1:0] signed_term(input logic [M_W-1:0] mag,
			input logic neg);
		logic [ACC_W-1:0] ext;
		ext = {{(ACC_W-M_W){1'b0}}, mag};
		return (ext ^ {ACC_W{neg}}) + ACC_W'(neg);
	endfunction

endpackage

// ===== design/plci_mac.sv =====
// ----------------------------------------------------------------------------
// plci_mac: shared multiply and round unit
// Stage 1 forms the unsigned product of two magnitudes; stage 2 rounds it
// half away from zero and shifts out the fraction bits. The sign rides along.
// ----------------------------------------------------------------------------
module plci_mac #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  plci_pkg::mul_req_t req,
	output plci_pkg::mul_res_t res
);
	import plci_pkg::*;

	logic           vld_s1;
	logic [P_W-1:0] p_s1;
	logic           neg_s1;
	logic [1:0]     sh_s1;
	logic [M_W-1:0] pe;
	logic [M_W-1:0] rnd;
	logic [M_W-1:0] mag_s2;
	logic           neg_s2;

	// Track which cycles carry a product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= req.vld;
		end
	end

	// Form the product of the magnitudes
	always_ff @(posedge clk) begin
		if (req.vld) begin
			p_s1   <= P_W'(req.a) * P_W'(req.b);
			neg_s1 <= req.neg;
			sh_s1  <= req.sh;
		end
	end

	// Add half an LSB of the result and drop the fraction bits
	assign pe = {1'b0, p_s1};

	always_comb begin
		unique case (sh_s1)
			SH_STEP: rnd = (pe + (M_W'(1) << (STEP_FRAC - 1))) >> STEP_FRAC;
			SH_LEAK: rnd = (pe + (M_W'(1) << (LEAK_FRAC - 1))) >> LEAK_FRAC;
			SH_GAIN: rnd = (pe + (M_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
			default: rnd = '0;
		endcase
	end

	// Hold the rounded result until the next product arrives
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			mag_s2 <= rnd;
			neg_s2 <= neg_s1;
		end
	end

	assign res = '{mag: mag_s2, neg: neg_s2};

endmodule

// ===== design/plci_bank.sv =====
// ----------------------------------------------------------------------------
// plci_bank: integrator storage, one 32-bit entry per actuator
// Synchronous memory with a registered read. A valid bit per entry,
// cleared at reset, makes an entry never written read back as zero.
// ----------------------------------------------------------------------------
module plci_bank #(
	parameter int DEPTH = 10,
	parameter int AW    = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic signed [31:0]   wr_data,
	output logic signed [31:0]   rd_data
);

	logic signed [31:0] mem [DEPTH];
	logic [DEPTH-1:0]   vld_q;
	logic signed [31:0] rd_data_q;
	logic               rd_vld_q;

	// Write and read the storage array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Mark written entries and sample the mark with the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== design/pid_leaky_clamped_integrator_core.sv =====
// ----------------------------------------------------------------------------
// pid_leaky_clamped_integrator_core: per-actuator PID with leaky clamped integrator
// Each input transaction is one actuator update; each output transaction is
// the saturated torque and the new integrator of that actuator.
// ----------------------------------------------------------------------------
// Usage:
//   s_t*   : input transactions, one update each (fields listed at s_tdata).
//   m_t*   : output transactions, one per input (fields listed at m_tdata).
//   cfg_*  : write of the step time register, always ready; write it only
//            while no update is in flight.
// Sequence: an accepted update steps through STEP, KD, KP, LEAK, ACC, CLAMP,
// KI, WAIT and OUT before it reaches the output register, and the next update
// is accepted only after that, so no new update is taken while one is in flight.
// The sequence is set by one shared multiply/round unit (two stages) that the
// five products of an update pass through, two of them depending on the
// integrator read-modify-write.
// Reset: all integrators read as zero, step time returns to 8389 (0.0005 s),
// the output register empties. No clearing sweep is needed.
// Stall: a finished result waits in the output register; the next update is
// accepted and worked on, and its result holds in the core until the output
// register frees up.
// ----------------------------------------------------------------------------
module pid_leaky_clamped_integrator_core #(
	parameter int NUM_ACTUATORS = 10,
	parameter int FRAC_BITS     = 16,
	localparam int IDX_W = (NUM_ACTUATORS > 1) ? $clog2(NUM_ACTUATORS) : 1,
	localparam int S_W   = ((IDX_W + 304 + 7) / 8) * 8,
	localparam int O_W   = ((IDX_W + 64 + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	// Input transactions
	input  logic           s_tvalid,
	output logic           s_tready,
	// actuator_index, feed_forward, position_target, velocity_target,
	// position_measured, velocity_measured, prop_gain, deriv_gain,
	// integ_gain, leak multiplier, integ_limit, zero fill
	input  logic [S_W-1:0] s_tdata,
	// Output transactions
	output logic           m_tvalid,
	input  logic           m_tready,
	// actuator_out, torque, integrator_value, zero fill
	output logic [O_W-1:0] m_tdata,
	// Step time register write
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [23:0]    cfg_data
);
	import plci_pkg::*;

	// Field offsets in s_tdata
	localparam int FF_LO   = IDX_W;
	localparam int QD_LO   = FF_LO + 32;
	localparam int VD_LO   = QD_LO + 32;
	localparam int QM_LO   = VD_LO + 32;
	localparam int VM_LO   = QM_LO + 32;
	localparam int KP_LO   = VM_LO + 32;
	localparam int KD_LO   = KP_LO + 32;
	localparam int KI_LO   = KD_LO + 32;
	localparam int LEAK_LO = KI_LO + 32;
	localparam int LIM_LO  = LEAK_LO + 17;

	localparam logic [23:0] STEP_RESET = 24'd8389;

	// Sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_STEP  = 4'd1;
	localparam logic [3:0] ST_KD    = 4'd2;
	localparam logic [3:0] ST_KP    = 4'd3;
	localparam logic [3:0] ST_LEAK  = 4'd4;
	localparam logic [3:0] ST_ACC   = 4'd5;
	localparam logic [3:0] ST_CLAMP = 4'd6;
	localparam logic [3:0] ST_KI    = 4'd7;
	localparam logic [3:0] ST_WAIT  = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	logic [3:0]  state_q;
	logic        s_acc;
	logic        out_free;
	logic [23:0] step_q;

	// Input fields
	logic [IDX_W-1:0]   in_idx;
	logic               in_idx_ok;
	logic signed [31:0] in_ff, in_qd, in_vd, in_qm, in_vm, in_kp, in_kd, in_ki;
	logic signed [32:0] pd_fw, pd_bw, vd_fw, vd_bw;
	logic [31:0]        kp_neg_v, kd_neg_v, ki_neg_v;

	// Latched update
	logic [IDX_W-1:0]   idx_q;
	logic               idx_ok_q;
	logic signed [31:0] ff_q;
	logic [32:0]        perr_mag_q, verr_mag_q;
	logic               perr_neg_q, verr_neg_q;
	logic [31:0]        kp_mag_q, kd_mag_q, ki_mag_q;
	logic               kp_neg_q, kd_neg_q, ki_neg_q;
	logic [16:0]        leak_q;
	logic [30:0]        lim_q;

	// Working values
	logic signed [31:0]      bank_rd;
	logic signed [31:0]      base;
	logic signed [33:0]      sum_q;
	logic [33:0]             sum_neg_v;
	logic [32:0]             sum_mag;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] sum_wide;
	logic signed [ACC_W-1:0] total;
	logic [30:0]             imag_q;
	logic                    ineg_q;
	logic [31:0]             integ_new;
	logic signed [31:0]      integ_q;
	logic                    sat_hi, sat_lo;
	logic [31:0]             torque_v;
	logic                    wr_en;

	mul_req_t mreq;
	mul_res_t mres;

	// Output register
	logic               m_vld_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic signed [31:0] torque_q;
	logic signed [31:0] out_integ_q;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid & s_tready;
	assign out_free  = !m_vld_q || m_tready;
	assign cfg_ready = 1'b1;

	// Step time register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			step_q <= cfg_data;
		end
	end

	// Unpack the input transaction
	assign in_idx    = s_tdata[IDX_W-1:0];
	assign in_idx_ok = {1'b0, in_idx} < (IDX_W + 1)'(NUM_ACTUATORS);
	assign in_ff     = s_tdata[FF_LO +: 32];
	assign in_qd     = s_tdata[QD_LO +: 32];
	assign in_vd     = s_tdata[VD_LO +: 32];
	assign in_qm     = s_tdata[QM_LO +: 32];
	assign in_vm     = s_tdata[VM_LO +: 32];
	assign in_kp     = s_tdata[KP_LO +: 32];
	assign in_kd     = s_tdata[KD_LO +: 32];
	assign in_ki     = s_tdata[KI_LO +: 32];

	// Errors as magnitude and sign: both differences in parallel, pick one
	assign pd_fw    = {in_qd[31], in_qd} - {in_qm[31], in_qm};
	assign pd_bw    = {in_qm[31], in_qm} - {in_qd[31], in_qd};
	assign vd_fw    = {in_vd[31], in_vd} - {in_vm[31], in_vm};
	assign vd_bw    = {in_vm[31], in_vm} - {in_vd[31], in_vd};
	assign kp_neg_v = -in_kp;
	assign kd_neg_v = -in_kd;
	assign ki_neg_v = -in_ki;

	// Latch the accepted update
	always_ff @(posedge clk) begin
		if (s_acc) begin
			idx_q      <= in_idx;
			idx_ok_q   <= in_idx_ok;
			ff_q       <= in_ff;
			perr_neg_q <= pd_fw[32];
			perr_mag_q <= pd_fw[32] ? pd_bw : pd_fw;
			verr_neg_q <= vd_fw[32];
			verr_mag_q <= vd_fw[32] ? vd_bw : vd_fw;
			kp_neg_q   <= in_kp[31];
			kp_mag_q   <= in_kp[31] ? kp_neg_v : in_kp;
			kd_neg_q   <= in_kd[31];
			kd_mag_q   <= in_kd[31] ? kd_neg_v : in_kd;
			ki_neg_q   <= in_ki[31];
			ki_mag_q   <= in_ki[31] ? ki_neg_v : in_ki;
			leak_q     <= s_tdata[LEAK_LO +: 17];
			lim_q      <= s_tdata[LIM_LO +: 31];
		end
	end

	// Advance the sequencer; hold in the last state until the output frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (s_acc) state_q <= ST_STEP;
				ST_STEP:  state_q <= ST_KD;
				ST_KD:    state_q <= ST_KP;
				ST_KP:    state_q <= ST_LEAK;
				ST_LEAK:  state_q <= ST_ACC;
				ST_ACC:   state_q <= ST_CLAMP;
				ST_CLAMP: state_q <= ST_KI;
				ST_KI:    state_q <= ST_WAIT;
				ST_WAIT:  state_q <= ST_OUT;
				ST_OUT:   if (out_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Integrator magnitude for the leak product
	assign sum_neg_v = -sum_q;
	assign sum_mag   = sum_q[33] ? sum_neg_v[32:0] : sum_q[32:0];

	// Issue products to the shared unit
	always_comb begin
		mreq = '{vld: 1'b0, a: '0, b: '0, neg: 1'b0, sh: SH_GAIN};
		unique case (state_q)
			ST_STEP: mreq = '{vld: 1'b1, a: perr_mag_q, b: {8'd0, step_q},
					neg: perr_neg_q, sh: SH_STEP};
			ST_KD:   mreq = '{vld: 1'b1, a: verr_mag_q, b: kd_mag_q,
					neg: verr_neg_q ^ kd_neg_q, sh: SH_GAIN};
			ST_KP:   mreq = '{vld: 1'b1, a: perr_mag_q, b: kp_mag_q,
					neg: perr_neg_q ^ kp_neg_q, sh: SH_GAIN};
			ST_LEAK: mreq = '{vld: 1'b1, a: sum_mag, b: {15'd0, leak_q},
					neg: sum_q[33], sh: SH_LEAK};
			ST_KI:   mreq = '{vld: 1'b1, a: {2'd0, imag_q}, b: ki_mag_q,
					neg: ki_neg_q ^ ineg_q, sh: SH_GAIN};
			default: mreq = '{vld: 1'b0, a: '0, b: '0, neg: 1'b0, sh: SH_GAIN};
		endcase
	end

	plci_mac #(
		.FRAC_BITS(FRAC_BITS)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mreq),
		.res   (mres)
	);

	// Integrator read-modify-write storage
	assign integ_new = ineg_q ? -{1'b0, imag_q} : {1'b0, imag_q};
	assign wr_en     = (state_q == ST_KI) && idx_ok_q;

	plci_bank #(
		.DEPTH(NUM_ACTUATORS),
		.AW   (IDX_W)
	) u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (s_acc && in_idx_ok),
		.rd_addr(in_idx),
		.wr_en  (wr_en),
		.wr_addr(idx_q),
		.wr_data(integ_new),
		.rd_data(bank_rd)
	);

	// Signed form of the rounded product and the running sums
	assign term     = signed_term(mres.mag, mres.neg);
	assign base     = idx_ok_q ? bank_rd : '0;
	assign sum_wide = {{(ACC_W-32){base[31]}}, base} + term;
	assign total    = acc_q + term;

	// Combine terms and clamp the integrator as results come out of the unit
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_KP:    sum_q <= sum_wide[33:0];
			ST_LEAK:  acc_q <= {{(ACC_W-32){ff_q[31]}}, ff_q} + term;
			ST_ACC:   acc_q <= acc_q + term;
			ST_CLAMP: begin
				ineg_q <= mres.neg;
				if (mres.mag > {{(M_W-31){1'b0}}, lim_q}) begin
					imag_q <= lim_q;
				end else begin
					imag_q <= mres.mag[30:0];
				end
			end
			ST_KI:    integ_q <= integ_new;
			default:  ;
		endcase
	end

	// Saturate the torque to 32 bits
	assign sat_hi   = !total[ACC_W-1] && (|total[ACC_W-2:31]);
	assign sat_lo   = total[ACC_W-1] && !(&total[ACC_W-2:31]);
	assign torque_v = sat_hi ? 32'h7FFF_FFFF : (sat_lo ? 32'h8000_0000 : total[31:0]);

	// Output register: load a finished update, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			m_vld_q <= 1'b1;
		end else if (m_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			out_idx_q   <= idx_q;
			torque_q    <= torque_v;
			out_integ_q <= integ_q;
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = {{(O_W - IDX_W - 64){1'b0}}, out_integ_q, torque_q, out_idx_q};

endmodule
